// ===== sv/crcfp_pkg.sv =====
package crcfp_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 256;
    localparam int unsigned OUTQ_DEPTH      = 3;

    localparam logic [7:0]  HDR_BYTE0 = 8'hA5;
    localparam logic [7:0]  HDR_BYTE1 = 8'h5A;
    localparam logic [7:0]  TAIL_BYTE = 8'hFF;
    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [15:0] CRC_INIT  = 16'h0000;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC    = 4'd1,
        PH_CMD     = 4'd2,
        PH_LEN_HI  = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CRC_HI  = 4'd6,
        PH_CRC_LO  = 4'd7,
        PH_TAIL    = 4'd8
    } phase_t;

    typedef struct packed {
        logic frame_ok;
        logic crc_mismatch;
        logic length_error;
    } parse_stat_t;

    typedef struct packed {
        parse_stat_t stat;
        logic [7:0]  frame_cmd;
        logic [15:0] frame_length;
        logic [7:0]  read_data;
    } out_item_t;

    // CRC-16 with unreflected poly 8005, shifted right: xor the byte into the low bits, then eight right shifts.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/crcfp_store.sv =====
module crcfp_store
    import crcfp_pkg::*;
#(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read word until the next read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/crcfp_parser.sv =====
module crcfp_parser
    import crcfp_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int unsigned DEPTH       = 256,
    parameter int unsigned ADDR_W      = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output parse_stat_t       stat,
    output logic [7:0]        frame_cmd,
    output logic [15:0]       frame_length,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output logic [7:0]        wdata
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);
    localparam logic [15:0] STORE_N = 16'(DEPTH);

    phase_t      phase_reg, phase_next;
    parse_stat_t stat_reg, stat_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  rcrc_hi_reg, rcrc_hi_next;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic [15:0] crc_byte;

    assign len_full  = {len_reg[15:8], rx_byte};
    assign count_inc = count_reg + 16'd1;
    assign crc_byte  = crc16_byte((phase_reg == PH_CMD) ? CRC_INIT : crc_reg, rx_byte);

    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            case (phase_reg)
                PH_HUNT:    phase_next = (rx_byte == HDR_BYTE0) ? PH_SYNC : PH_HUNT;
                PH_SYNC:    phase_next = (rx_byte == HDR_BYTE1) ? PH_CMD : PH_HUNT;
                PH_CMD:     phase_next = PH_LEN_HI;
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO: begin
                    if (len_full > MAX_LEN) begin
                        phase_next = PH_HUNT;
                    end else if (len_full == 16'd0) begin
                        phase_next = PH_CRC_HI;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: phase_next = (count_inc >= len_reg) ? PH_CRC_HI : PH_PAYLOAD;
                PH_CRC_HI:  phase_next = PH_CRC_LO;
                PH_CRC_LO:  phase_next = ({rcrc_hi_reg, rx_byte} == crc_reg) ? PH_TAIL : PH_HUNT;
                PH_TAIL:    phase_next = PH_HUNT;
                default:    phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        stat_next    = '0;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        rcrc_hi_next = rcrc_hi_reg;
        we           = 1'b0;
        if (step) begin
            case (phase_reg)
                PH_CMD: begin
                    cmd_next = rx_byte;
                    crc_next = crc_byte;
                end
                PH_LEN_HI: begin
                    len_next = {rx_byte, 8'h00};
                    crc_next = crc_byte;
                end
                PH_LEN_LO: begin
                    len_next               = len_full;
                    crc_next               = crc_byte;
                    count_next             = 16'd0;
                    stat_next.length_error = (len_full > MAX_LEN);
                end
                PH_PAYLOAD: begin
                    crc_next   = crc_byte;
                    count_next = count_inc;
                    we         = (count_reg < STORE_N);
                end
                PH_CRC_HI:  rcrc_hi_next = rx_byte;
                PH_CRC_LO:  stat_next.crc_mismatch = ({rcrc_hi_reg, rx_byte} != crc_reg);
                PH_TAIL:    stat_next.frame_ok = (rx_byte == TAIL_BYTE);
                default: ;
            endcase
        end
    end

    assign waddr = count_reg[ADDR_W-1:0];
    assign wdata = rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            stat_reg  <= '0;
            cmd_reg   <= 8'h00;
            len_reg   <= 16'h0000;
        end else begin
            phase_reg <= phase_next;
            stat_reg  <= stat_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        crc_reg     <= crc_next;
        rcrc_hi_reg <= rcrc_hi_next;
    end

    assign stat         = stat_reg;
    assign frame_cmd    = cmd_reg;
    assign frame_length = len_reg;

endmodule

// ===== sv/crcfp_outq.sv =====
module crcfp_outq
    import crcfp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      pop,
    output logic      head_valid,
    output out_item_t head_item,
    output logic [1:0] count
);

    out_item_t  slot_reg [OUTQ_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign do_pop = pop && (count_reg != 2'd0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// ===== sv/crc_checked_frame_parser.sv =====
// Frame parser for a UART byte stream: A5 5A, command, length (MSB first),
// payload, CRC-16 (MSB first), FF tail. The CRC covers command, length and
// payload.
//
// Input channel (s_valid/s_ready): each transaction carries s_mode. Mode 0
// feeds s_rx_byte to the parser; mode 1 reads the stored payload byte at
// s_read_index. Every input transaction yields exactly one result on the
// m_ channel, in order.
//
// From input acceptance to m_valid, a transaction passes the parser registers
// and the payload RAM read port, then the result queue.
// Throughput is one transaction per cycle while m_ready stays high.
// A three-entry result queue sits in front of m_; s_ready drops only when
// the queue plus the transaction in flight fill it, so up to three
// transactions are taken while m_ready is low.
//
// Reset (aresetn low, synchronous) returns the parser to header hunting,
// clears command and length to zero and empties the queue. Payload RAM is
// not cleared; read only positions written by an earlier frame.
module crc_checked_frame_parser
    import crcfp_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_ok,
    output logic [7:0]  m_frame_cmd,
    output logic [15:0] m_frame_length,
    output logic [7:0]  m_read_data,
    output logic        m_crc_mismatch,
    output logic        m_length_error
);

    // Only the first 256 positions are reachable by an 8-bit index.
    localparam int unsigned DEPTH  = (MAX_PAYLOAD < 256) ? MAX_PAYLOAD : 256;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              accept;
    logic              rd_hit;
    logic              a_valid_reg;
    logic              a_rd_reg;
    parse_stat_t       stat;
    logic [7:0]        cmd;
    logic [15:0]       len;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [7:0]        mem_rdata;
    out_item_t         push_item;
    out_item_t         head_item;
    logic [1:0]        q_count;

    assign accept = s_valid && s_ready;
    assign rd_hit = accept && s_mode && ({8'h00, s_read_index} < 16'(MAX_PAYLOAD));

    // Reserve a queue slot for the transaction still in the first stage.
    assign s_ready = ({1'b0, q_count} + {2'b00, a_valid_reg}) < 3'(OUTQ_DEPTH);

    crcfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (accept && !s_mode),
        .rx_byte      (s_rx_byte),
        .stat         (stat),
        .frame_cmd    (cmd),
        .frame_length (len),
        .we           (we),
        .waddr        (waddr),
        .wdata        (wdata)
    );

    crcfp_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_hit),
        .raddr (s_read_index[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        a_rd_reg <= rd_hit;
    end

    always_comb begin
        push_item.stat         = stat;
        push_item.frame_cmd    = cmd;
        push_item.frame_length = len;
        push_item.read_data    = a_rd_reg ? mem_rdata : 8'h00;
    end

    crcfp_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (a_valid_reg),
        .push_item  (push_item),
        .pop        (m_ready),
        .head_valid (m_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    assign m_frame_ok     = head_item.stat.frame_ok;
    assign m_crc_mismatch = head_item.stat.crc_mismatch;
    assign m_length_error = head_item.stat.length_error;
    assign m_frame_cmd    = head_item.frame_cmd;
    assign m_frame_length = head_item.frame_length;
    assign m_read_data    = head_item.read_data;

endmodule

// ===== sv/crcfp_checker.sv =====
module crcfp_checker
    import crcfp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_frame_ok,
    input logic [7:0]  m_read_data,
    input logic        m_crc_mismatch,
    input logic        m_length_error
);

    // A result is never shown in the cycle after reset was applied.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A transaction ends a frame in at most one way.
    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_frame_ok, m_crc_mismatch, m_length_error}))
        else $error("more than one frame status flag");

    // Frame status comes from received bytes, which never carry read data.
    a_flag_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_ok || m_crc_mismatch || m_length_error)
            |-> m_read_data == 8'h00)
        else $error("read data on a receive result");

    // With the output draining, a stall on the input is released at once.
    a_no_starve: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && $past(aresetn) && $past(m_ready) && m_ready |=> s_ready)
        else $error("input stalled while output drains");

endmodule

bind crc_checked_frame_parser crcfp_checker u_crcfp_checker (.*);

// ===== tb/tb_crc_checked_frame_parser.sv =====
module tb_crc_checked_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfp_pkg::*;

    localparam int unsigned CAP         = MAX_PAYLOAD_DEF;
    localparam int          GEN         = 0;  // shadow parser used while building the stream
    localparam int          CHK         = 1;  // parser that predicts the DUT results
    localparam int          N_ITEMS     = 1500;
    localparam int          HOLD_CYCLES = 200;
    localparam logic        MODE_RX     = 1'b0;
    localparam logic        MODE_READ   = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx;
        logic [7:0] idx;
    } uart_item_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [7:0]  rdata;
        logic        mism;
        logic        lerr;
    } frame_res_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_mode         = 1'b0;
    logic [7:0]  s_rx_byte      = 8'h00;
    logic [7:0]  s_read_index   = 8'h00;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_frame_ok;
    logic [7:0]  m_frame_cmd;
    logic [15:0] m_frame_length;
    logic [7:0]  m_read_data;
    logic        m_crc_mismatch;
    logic        m_length_error;

    // two copies of the parser state, one per role
    phase_t      ph     [2];
    logic [7:0]  cmd_r  [2];
    logic [15:0] len_r  [2];
    logic [15:0] cnt_r  [2];
    logic [15:0] crc_r  [2];
    logic [15:0] rcrc_r [2];
    logic [7:0]  store  [2][CAP];

    bit          written [CAP];
    int          written_idx [$];
    uart_item_t  uart_items [$];
    frame_res_t  predicted_out [$];

    int  read_pct     = 0;
    int  errors       = 0;
    int  results_seen = 0;
    int  sent         = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  rcv_ticks    = 0;
    bit  in_flight    = 1'b0;
    bit  took         = 1'b0;
    bit  drv_calm     = 1'b0;
    bit  rcv_calm     = 1'b0;
    bit  hold         = 1'b0;

    crc_checked_frame_parser i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_rx_byte      (s_rx_byte),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_ok     (m_frame_ok),
        .m_frame_cmd    (m_frame_cmd),
        .m_frame_length (m_frame_length),
        .m_read_data    (m_read_data),
        .m_crc_mismatch (m_crc_mismatch),
        .m_length_error (m_length_error)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic frame_res_t parse_step(int m, logic md, logic [7:0] b, logic [7:0] idx);
        frame_res_t res;
        res = '0;
        if (md == MODE_READ) begin
            res.rdata = store[m][idx];
        end else begin
            case (ph[m])
                PH_HUNT: begin
                    if (b == HDR_BYTE0) ph[m] = PH_SYNC;
                end
                PH_SYNC: begin
                    ph[m] = (b == HDR_BYTE1) ? PH_CMD : PH_HUNT;
                end
                PH_CMD: begin
                    cmd_r[m] = b;
                    crc_r[m] = crc_next(CRC_INIT, b);
                    ph[m] = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_r[m] = {b, 8'h00};
                    crc_r[m] = crc_next(crc_r[m], b);
                    ph[m] = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_r[m] = {len_r[m][15:8], b};
                    crc_r[m] = crc_next(crc_r[m], b);
                    cnt_r[m] = '0;
                    if (len_r[m] > CAP) begin
                        res.lerr = 1'b1;
                        ph[m] = PH_HUNT;
                    end else if (len_r[m] == 16'd0) begin
                        ph[m] = PH_CRC_HI;
                    end else begin
                        ph[m] = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (cnt_r[m] < CAP) begin
                        store[m][cnt_r[m][7:0]] = b;
                        if (m == GEN && !written[cnt_r[m][7:0]]) begin
                            written[cnt_r[m][7:0]] = 1'b1;
                            written_idx.push_back(int'(cnt_r[m][7:0]));
                        end
                    end
                    crc_r[m] = crc_next(crc_r[m], b);
                    cnt_r[m] = cnt_r[m] + 16'd1;
                    if (cnt_r[m] >= len_r[m]) ph[m] = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    rcrc_r[m] = {8'h00, b};
                    ph[m] = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    rcrc_r[m] = {rcrc_r[m][7:0], b};
                    if (rcrc_r[m] == crc_r[m]) begin
                        ph[m] = PH_TAIL;
                    end else begin
                        res.mism = 1'b1;
                        ph[m] = PH_HUNT;
                    end
                end
                PH_TAIL: begin
                    ph[m] = PH_HUNT;
                    res.ok = (b == TAIL_BYTE);
                end
                default: ph[m] = PH_HUNT;
            endcase
        end
        res.cmd = cmd_r[m];
        res.len = len_r[m];
        return res;
    endfunction

    task automatic add_item(logic md, logic [7:0] b, logic [7:0] idx);
        frame_res_t unused;
        uart_items.push_back('{md, b, idx});
        unused = parse_step(GEN, md, b, idx);
    endtask

    // only positions some frame has written are ever read
    task automatic send_read();
        add_item(MODE_READ, 8'($urandom_range(0, 255)),
                 8'(written_idx[$urandom_range(0, written_idx.size() - 1)]));
    endtask

    task automatic send_byte(logic [7:0] b);
        if (written_idx.size() > 0 && $urandom_range(0, 99) < read_pct) send_read();
        add_item(MODE_RX, b, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(logic [7:0] cmd, logic [15:0] len, bit bad_crc, logic [7:0] tail);
        logic [15:0] c;
        logic [7:0]  p;
        c = CRC_INIT;
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
        send_byte(cmd);
        c = crc_next(c, cmd);
        send_byte(len[15:8]);
        c = crc_next(c, len[15:8]);
        send_byte(len[7:0]);
        c = crc_next(c, len[7:0]);
        if (len > CAP) return;
        for (int n = 0; n < int'(len); n++) begin
            p = 8'($urandom_range(0, 255));
            send_byte(p);
            c = crc_next(c, p);
        end
        if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        send_byte(tail);
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        if (r < 88) return 16'($urandom_range(1, 16));
        if (r < 92) return 16'($urandom_range(17, 255));
        if (r < 93) return 16'(CAP);
        if (r < 98) return 16'($urandom_range(CAP + 1, 65535));
        return 16'hFFFF;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_error(string msg);
        if (errors < 50) $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h expected %0h (result %0d)",
                                   name, got, want, results_seen));
    endtask

    // driver: present the next transaction, hold it until accepted
    always @(negedge aclk) begin : drv
        uart_item_t nxt;
        if (aresetn !== 1'b1) begin
            s_valid <= 1'b0;
        end else begin
            if (took) begin
                in_flight = 1'b0;
                took = 1'b0;
            end
            if (!in_flight) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (uart_items.size() > 0) begin
                    nxt = uart_items.pop_front();
                    s_mode       <= nxt.mode;
                    s_rx_byte    <= nxt.rx;
                    s_read_index <= nxt.idx;
                    s_valid      <= 1'b1;
                    in_flight = 1'b1;
                    sent++;
                    if (sent % 100 == 0) drv_calm = ($urandom_range(0, 3) == 0);
                    gap_left = drv_calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin : rcv
        bit rdy;
        rdy = 1'b0;
        if (aresetn === 1'b1) begin
            rcv_ticks++;
            if (rcv_ticks % 128 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
            if (stall_left > 0) begin
                stall_left--;
            end else begin
                rdy = 1'b1;
                if (!rcv_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
        m_ready <= rdy && !hold;
    end

    // monitor: check the result transaction, then predict for the input transaction
    always @(posedge aclk) begin : mon
        frame_res_t got;
        frame_res_t want;
        if (aresetn === 1'b1) begin
            if (m_valid && m_ready) begin
                got = '{m_frame_ok, m_frame_cmd, m_frame_length, m_read_data,
                        m_crc_mismatch, m_length_error};
                if (predicted_out.size() == 0) begin
                    report_error("result transaction with nothing outstanding");
                end else begin
                    want = predicted_out.pop_front();
                    check_field("frame_ok", 16'(got.ok), 16'(want.ok));
                    check_field("frame_cmd", 16'(got.cmd), 16'(want.cmd));
                    check_field("frame_length", got.len, want.len);
                    check_field("read_data", 16'(got.rdata), 16'(want.rdata));
                    check_field("crc_mismatch", 16'(got.mism), 16'(want.mism));
                    check_field("length_error", 16'(got.lerr), 16'(want.lerr));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                predicted_out.push_back(parse_step(CHK, s_mode, s_rx_byte, s_read_index));
                took = 1'b1;
            end
        end
    end

    // hold off the receiver long enough to fill the result queue and stall the input
    initial begin
        while (results_seen < 400) @(posedge aclk);
        hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int k;
        for (int m = 0; m < 2; m++) begin
            ph[m]     = PH_HUNT;
            cmd_r[m]  = '0;
            len_r[m]  = '0;
            cnt_r[m]  = '0;
            crc_r[m]  = '0;
            rcrc_r[m] = '0;
        end

        // directed: good empty frame, A5 as second byte, oversize length, bad tail, read
        send_frame(8'hFF, 16'd0, 1'b0, TAIL_BYTE);
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE0);
        send_frame(8'h00, 16'hFFFF, 1'b0, TAIL_BYTE);
        send_frame(8'h3C, 16'd1, 1'b0, 8'h00);
        send_read();

        // random: mostly well-formed frames, some broken ones and noise
        read_pct = 8;
        send_frame(8'($urandom_range(0, 255)), 16'(CAP), 1'b0, TAIL_BYTE);
        while (uart_items.size() < N_ITEMS) begin
            k = $urandom_range(0, 99);
            if (k < 65) begin
                send_frame(8'($urandom_range(0, 255)), pick_len(), $urandom_range(0, 9) == 0,
                           ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 254)) : TAIL_BYTE);
            end else if (k < 75) begin
                repeat ($urandom_range(1, 6)) send_read();
            end else if (k < 85) begin
                send_byte(HDR_BYTE0);
                if ($urandom_range(0, 1)) send_byte(HDR_BYTE1);
                repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end
            // drain a broken frame back to hunting
            while (ph[GEN] != PH_HUNT) send_byte(8'($urandom_range(0, 255)));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (uart_items.size() > 0 || in_flight || predicted_out.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/crcfp_pkg.sv
sv/crcfp_store.sv
sv/crcfp_parser.sv
sv/crcfp_outq.sv
sv/crc_checked_frame_parser.sv
sv/crcfp_checker.sv
tb/tb_crc_checked_frame_parser.sv
